FILE: sv/i2a_pkg.sv
// Shared types, constants and helpers for the integer to decimal text core.
// Used by every module of the core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

   localparam int unsigned BIN_W       = 32;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned NUM_DIGITS  = 10;
   localparam int unsigned BCD_W       = NUM_DIGITS * DIGIT_W;
   localparam int unsigned CHAR_W      = 7;
   localparam int unsigned IDX_W       = 4;
   // bits of the binary magnitude consumed by each shift-add stage
   localparam int unsigned STAGE_BITS  = 8;
   localparam int unsigned NUM_STAGES  = BIN_W / STAGE_BITS;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_type;

   // one word in flight through the conversion pipeline
   typedef struct packed {
      logic                 neg;
      bcd_type              bcd;
      logic [BIN_W-1:0]     bin;
   } work_type;

   // correct every digit that would overflow on the next doubling
   function automatic bcd_type bcd_adjust(input bcd_type d);
      bcd_type r;
      r = d;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (d[i] >= 4'd5) begin
            r[i] = d[i] + 4'd3;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/i2a_dabble_stage.sv
// One register stage of the shift-add-3 binary to BCD converter.
// Depends on i2a_pkg (work_type, bcd_adjust, STAGE_BITS).
`timescale 1ns / 1ps
`default_nettype none

module i2a_dabble_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire i2a_pkg::work_type in_work,
   output logic                   out_valid_ff,
   output i2a_pkg::work_type      out_work_ff
);
   import i2a_pkg::*;

   work_type work_in;

   // shift STAGE_BITS magnitude bits into the digit field
   always_comb begin
      work_in = in_work;
      for (int s = 0; s < STAGE_BITS; s++) begin
         work_in.bcd = bcd_adjust(work_in.bcd);
         {work_in.bcd, work_in.bin} = {work_in.bcd, work_in.bin} << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_work_ff <= work_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/i2a_serializer.sv
// Character serializer: takes a finished BCD word and emits sign and digits.
// Depends on i2a_pkg (bcd_type, character constants, widths).
`timescale 1ns / 1ps
`default_nettype none

module i2a_serializer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load,
   input  wire logic                        load_neg,
   input  wire i2a_pkg::bcd_type            load_bcd,
   output logic                             ready,
   output logic                             rsp_strobe,
   output logic [i2a_pkg::CHAR_W-1:0]       rsp_char_code,
   output logic                             rsp_is_last
);
   import i2a_pkg::*;

   logic               active_ff, active_in;
   logic               sign_ff, sign_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   bcd_type            bcd_ff;
   logic [IDX_W-1:0]   top_idx;

   // index of the most significant nonzero digit; zero keeps one digit
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (load_bcd[i] != '0) begin
            top_idx = IDX_W'(i);
         end
      end
   end

   assign ready = !active_ff || (!sign_ff && idx_ff == '0);

   always_comb begin
      active_in     = active_ff;
      sign_in       = sign_ff;
      idx_in        = idx_ff;
      rsp_strobe    = active_ff;
      rsp_char_code = sign_ff ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(bcd_ff[idx_ff]));
      rsp_is_last   = active_ff && !sign_ff && idx_ff == '0;
      if (active_ff) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else if (idx_ff == '0) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
      if (load) begin
         active_in = 1'b1;
         sign_in   = load_neg;
         idx_in    = top_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         sign_ff   <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         sign_ff   <= sign_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bcd_ff <= load_bcd;
      end
   end

endmodule

`default_nettype wire

FILE: sv/signed_int_to_decimal_ascii_core.sv
// Top level of the signed 32-bit integer to decimal ASCII text core.
// Depends on i2a_pkg, i2a_dabble_stage and i2a_serializer.
`timescale 1ns / 1ps
`default_nettype none

// Converts one signed 32-bit word to its decimal text, most significant
// character first: a leading '-' for negative values, no leading zeros, and
// a single '0' for zero; the most negative value gives "-2147483648". A word
// is taken when start is high and busy is low. One character comes out per
// cycle on rsp_char_code, marked by rsp_strobe, with rsp_is_last on the final
// one; the receiver cannot stall, so every strobed character must be taken.
// A taken word passes through one magnitude stage, four shift-add-3 stages
// of eight bits each, then the serializer. A word has 1 to 11 characters,
// and the serializer, which takes the next word on the final character of
// the current one, sets the sustained rate; up to five more words queue in
// the pipeline behind it.
// Busy is high while a word waits in the last shift-add-3 stage and the
// serializer is emitting but not on its final character; the whole pipeline
// then holds, even if earlier stages are empty.
module signed_int_to_decimal_ascii_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [31:0]          req_value,
   output logic                             rsp_strobe,
   output logic [i2a_pkg::CHAR_W-1:0]       rsp_char_code,
   output logic                             rsp_is_last
);
   import i2a_pkg::*;

   logic                 advance;
   logic                 ser_ready;
   logic                 s0_valid_ff;
   work_type             s0_work_ff, s0_work_in;
   logic [NUM_STAGES:0]  stg_valid;
   work_type             stg_work [NUM_STAGES+1];

   // The whole pipeline moves as one: it advances whenever the last stage is
   // empty or the serializer can take its word this cycle.
   assign advance = !stg_valid[NUM_STAGES] || ser_ready;
   assign busy    = !advance;

   // Stage 0: take the magnitude as unsigned so the most negative value works.
   always_comb begin
      s0_work_in.neg = req_value[BIN_W-1];
      s0_work_in.bcd = '0;
      s0_work_in.bin = req_value[BIN_W-1] ? (BIN_W'(0) - BIN_W'(req_value))
                                          : BIN_W'(req_value);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_work_ff <= s0_work_in;
      end
   end

   assign stg_valid[0] = s0_valid_ff;
   assign stg_work[0]  = s0_work_ff;

   // Shift-add-3 stages, eight magnitude bits each.
   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
      i2a_dabble_stage u_stage (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .in_valid     (stg_valid[g]),
         .in_work      (stg_work[g]),
         .out_valid_ff (stg_valid[g+1]),
         .out_work_ff  (stg_work[g+1])
      );
   end

   // Hand the finished word to the serializer when it frees up.
   i2a_serializer u_ser (
      .clock         (clock),
      .reset         (reset),
      .load          (stg_valid[NUM_STAGES] && ser_ready),
      .load_neg      (stg_work[NUM_STAGES].neg),
      .load_bcd      (stg_work[NUM_STAGES].bcd),
      .ready         (ser_ready),
      .rsp_strobe    (rsp_strobe),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

   // A minus sign is never the final character of a word.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_char_code == CHAR_MINUS |-> !rsp_is_last)
      else $error("minus sign marked as last character");

   // Every strobed character is a minus sign or a decimal digit.
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_char_code == CHAR_MINUS ||
                     (rsp_char_code >= CHAR_ZERO && rsp_char_code <= CHAR_ZERO + 7'd9))
      else $error("character outside sign and digit codes");

   // An accepted word enters stage 0.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> s0_valid_ff)
      else $error("accepted word lost at pipeline entry");

   // Busy only when the serializer is still emitting a word.
   a_busy_means_emitting: assert property (@(posedge clock) disable iff (reset)
      busy |-> rsp_strobe && !rsp_is_last)
      else $error("pipeline stalled while serializer is free");

   // After the last character, the serializer never stalls a waiting word.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_last && stg_valid[NUM_STAGES] |=> rsp_strobe)
      else $error("waiting word not loaded after last character");

endmodule

`default_nettype wire
